>>> src/pgw_pkg.sv
`default_nettype none

package pgw_pkg;

   // Default grid and robot limits.
   localparam int MAX_ROWS_DEFAULT    = 64;
   localparam int MAX_COLUMNS_DEFAULT = 64;
   localparam int MAX_ROBOTS_DEFAULT  = 16;

   // Fixed field widths.
   localparam int DIM_W   = 7;
   localparam int GAIN_W  = 16;
   localparam int LEVEL_W = 17;
   localparam int MARK_W  = 2;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 3;

   // One in unsigned Q1.16.
   localparam logic [LEVEL_W-1:0] ONE_Q16 = 17'd65536;

   // Register reset values.
   localparam logic [GAIN_W-1:0] DEPOSIT_GAIN_RESET = 16'd14300;
   localparam logic [GAIN_W-1:0] SELF_GAIN_RESET    = 16'd42598;
   localparam logic [GAIN_W-1:0] EVAP_RATE_RESET    = 16'd3277;
   localparam int                GRID_DIM_RESET     = 64;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLUMNS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPOSIT_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SELF_GAIN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EVAP_RATE    = 3'd4;

   // Request codes.
   localparam logic [2:0] REQ_CLEAR = 3'd0;
   localparam logic [2:0] REQ_PLACE = 3'd1;
   localparam logic [2:0] REQ_MOVE  = 3'd2;
   localparam logic [2:0] REQ_EVAP  = 3'd3;
   localparam logic [2:0] REQ_READ  = 3'd4;

   // Status codes.
   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_REFUSED = 2'd1;
   localparam logic [1:0] STATUS_BAD     = 2'd2;

   // Cell marks.
   localparam logic [MARK_W-1:0] MARK_FREE    = 2'd0;
   localparam logic [MARK_W-1:0] MARK_VISITED = 2'd1;
   localparam logic [MARK_W-1:0] MARK_ROBOT   = 2'd2;

   // Deposit: the level moves towards one by the given fraction of the gap.
   function automatic logic [LEVEL_W-1:0] deposit_level(input logic [LEVEL_W-1:0] lvl,
                                                        input logic [GAIN_W-1:0] gain);
      logic [LEVEL_W-1:0] sat;
      logic [32:0]        prod;
      sat  = (lvl > ONE_Q16) ? ONE_Q16 : lvl;
      prod = 33'(ONE_Q16 - sat) * 33'(gain);
      return sat + prod[32:16];
   endfunction

   // Evaporation: the level loses the given fraction of itself.
   function automatic logic [LEVEL_W-1:0] evaporate_level(input logic [LEVEL_W-1:0] lvl,
                                                          input logic [GAIN_W-1:0] rate);
      logic [32:0] prod;
      prod = 33'(lvl) * 33'(rate);
      return lvl - prod[32:16];
   endfunction

   // Interior test on coordinates that carry an offset of one, so that the
   // neighbour above row zero never goes negative.
   function automatic logic interior_plus1(input logic [8:0] r1, input logic [8:0] c1,
                                           input logic [DIM_W-1:0] rows,
                                           input logic [DIM_W-1:0] cols);
      return (r1 >= 9'd2) && (c1 >= 9'd2) && (r1 < 9'(rows)) && (c1 < 9'(cols));
   endfunction

endpackage

`default_nettype wire

>>> src/pgw_ram.sv
`default_nettype none

module pgw_ram #(
   parameter int WIDTH = 17,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/pheromone_grid_robot_walk_unit.sv
// A move does a read-modify-write of the level memory for each interior neighbour, then
// steps the roulette. Evaporate reads and writes back each interior cell; clear sweeps
// every memory entry, one a cycle.
// One request at a time: the next is taken once the result is in the output register.
// Reset is synchronous: after it the block sweeps both memories to zero (4096 entries
// at the default size) and takes no request until that is done.
`default_nettype none

module pheromone_grid_robot_walk_unit #(
   parameter int MAX_ROWS    = pgw_pkg::MAX_ROWS_DEFAULT,
   parameter int MAX_COLUMNS = pgw_pkg::MAX_COLUMNS_DEFAULT,
   parameter int MAX_ROBOTS  = pgw_pkg::MAX_ROBOTS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Configuration port.
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data,
   // Request channel.
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_type,
   input  wire logic [5:0]  req_cell_row,
   input  wire logic [5:0]  req_cell_col,
   input  wire logic [3:0]  req_robot_index,
   input  wire logic [15:0] req_random_fraction,
   // Result channel.
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [5:0]       rsp_robot_row,
   output logic [5:0]       rsp_robot_col,
   output logic [16:0]      rsp_level,
   output logic [1:0]       rsp_cell_mark,
   output logic             rsp_is_wall
);

   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLUMNS);
   localparam int AW    = RW + CW;
   localparam int DEPTH = 1 << AW;
   localparam int IW    = (MAX_ROBOTS > 1) ? $clog2(MAX_ROBOTS) : 1;
   localparam int PW    = $clog2(MAX_ROBOTS + 1);
   localparam int ROWS_RESET = (pgw_pkg::GRID_DIM_RESET > MAX_ROWS) ? MAX_ROWS :
                               pgw_pkg::GRID_DIM_RESET;
   localparam int COLS_RESET = (pgw_pkg::GRID_DIM_RESET > MAX_COLUMNS) ? MAX_COLUMNS :
                               pgw_pkg::GRID_DIM_RESET;
   localparam int LW = pgw_pkg::LEVEL_W;
   localparam int GW = pgw_pkg::GAIN_W;
   localparam int DW = pgw_pkg::DIM_W;
   localparam int MW = pgw_pkg::MARK_W;

   typedef enum logic [12:0] {
      S_IDLE      = 13'b0000000000001,
      S_SWEEP     = 13'b0000000000010,
      S_PLACE_CHK = 13'b0000000000100,
      S_READ_WAIT = 13'b0000000001000,
      S_NB_ADDR   = 13'b0000000010000,
      S_NB_DATA   = 13'b0000000100000,
      S_OWN_DATA  = 13'b0000001000000,
      S_ROUL_PREP = 13'b0000010000000,
      S_ROUL      = 13'b0000100000000,
      S_MARK_OLD  = 13'b0001000000000,
      S_MARK_NEW  = 13'b0010000000000,
      S_EVAP_ADDR = 13'b0100000000000,
      S_EVAP_DATA = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic             resp_pend_ff, resp_pend_in;
   logic [AW-1:0]    sweep_addr_ff, sweep_addr_in;
   logic             sweep_resp_ff, sweep_resp_in;

   logic [DW-1:0]    grows_ff, grows_in, gcols_ff, gcols_in;
   logic [GW-1:0]    dgain_ff, dgain_in, sgain_ff, sgain_in, erate_ff, erate_in;

   logic [PW-1:0]    placed_ff, placed_in;
   logic [RW-1:0]    pos_row_ff [MAX_ROBOTS];
   logic [CW-1:0]    pos_col_ff [MAX_ROBOTS];

   logic [RW-1:0]    row_ff, row_in;
   logic [CW-1:0]    col_ff, col_in;
   logic             in_range_ff, in_range_in;
   logic             wall_ff, wall_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [15:0]      rnd_ff, rnd_in;

   logic [RW-1:0]    pr_ff, pr_in;
   logic [CW-1:0]    pc_ff, pc_in;
   logic [1:0]       dr_ff, dr_in, dc_ff, dc_in;
   logic [3:0]       n_ff, n_in;
   logic [19:0]      sum_ff, sum_in;
   logic [LW-1:0]    w_ff [8];
   logic [RW-1:0]    nr_ff [8];
   logic [CW-1:0]    nc_ff [8];
   logic [35:0]      prod_ff, prod_in;
   logic [19:0]      acc_ff, acc_in;
   logic [2:0]       j_ff, j_in, pick_ff, pick_in;
   logic [RW-1:0]    er_ff, er_in;
   logic [CW-1:0]    ec_ff, ec_in;

   logic [1:0]       res_status_ff, res_status_in;
   logic [5:0]       res_row_ff, res_row_in, res_col_ff, res_col_in;
   logic [LW-1:0]    res_level_ff, res_level_in;
   logic [MW-1:0]    res_mark_ff, res_mark_in;
   logic             res_wall_ff, res_wall_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff;
   logic [5:0]       rsp_row_ff, rsp_col_ff;
   logic [LW-1:0]    rsp_level_ff;
   logic [MW-1:0]    rsp_mark_ff;
   logic             rsp_wall_ff;

   // Memory ports and array write controls.
   logic             ph_we, mk_we;
   logic [AW-1:0]    ph_waddr, ph_raddr, mk_waddr, mk_raddr;
   logic [LW-1:0]    ph_wdata, ph_rdata;
   logic [MW-1:0]    mk_wdata, mk_rdata;
   logic             pos_we, slot_we, rsp_load;
   logic [IW-1:0]    pos_widx;
   logic [RW-1:0]    pos_wrow;
   logic [CW-1:0]    pos_wcol;
   logic [LW-1:0]    slot_w;

   // Combinational helpers.
   logic [8:0]       req_r1, req_c1, slot_r1, slot_c1, own_r1, own_c1;
   logic [RW-1:0]    slot_row;
   logic [CW-1:0]    slot_col;
   logic             slot_ok, own_ok, req_acc;
   logic [LW-1:0]    dep_level;
   logic [19:0]      acc_next;
   logic [35:0]      acc_scaled;
   logic [IW-1:0]    req_idx;
   logic [6:0]       clamp_v;

   pgw_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_level_ram (
      .clock   (clock),
      .wr_en   (ph_we),
      .wr_addr (ph_waddr),
      .wr_data (ph_wdata),
      .rd_addr (ph_raddr),
      .rd_data (ph_rdata)
   );

   pgw_ram #(.WIDTH(MW), .DEPTH(DEPTH)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mk_we),
      .wr_addr (mk_waddr),
      .wr_data (mk_wdata),
      .rd_addr (mk_raddr),
      .rd_data (mk_rdata)
   );

   // Neighbour and own-cell coordinates, offset by one row and column.
   assign req_r1   = 9'(req_cell_row) + 9'd1;
   assign req_c1   = 9'(req_cell_col) + 9'd1;
   assign slot_r1  = 9'(pr_ff) + 9'(dr_ff);
   assign slot_c1  = 9'(pc_ff) + 9'(dc_ff);
   assign own_r1   = 9'(pr_ff) + 9'd1;
   assign own_c1   = 9'(pc_ff) + 9'd1;
   assign slot_row = RW'(slot_r1 - 9'd1);
   assign slot_col = CW'(slot_c1 - 9'd1);
   assign slot_ok  = pgw_pkg::interior_plus1(slot_r1, slot_c1, grows_ff, gcols_ff) &&
                     !(dr_ff == 2'd1 && dc_ff == 2'd1);
   assign own_ok   = pgw_pkg::interior_plus1(own_r1, own_c1, grows_ff, gcols_ff);
   assign req_acc  = req_valid && !req_stall;
   assign req_idx  = IW'(req_robot_index);
   assign dep_level = pgw_pkg::deposit_level(ph_rdata, (state_ff == S_OWN_DATA) ?
                                             sgain_ff : dgain_ff);
   assign acc_next   = acc_ff + 20'(w_ff[j_ff]);
   assign acc_scaled = {acc_next, 16'd0} - 36'(acc_next);
   assign clamp_v    = csr_data[6:0];
   assign req_stall  = (state_ff != S_IDLE) || resp_pend_ff;

   // Main sequencer.
   always_comb begin
      state_in      = state_ff;
      resp_pend_in  = resp_pend_ff;
      sweep_addr_in = sweep_addr_ff;
      sweep_resp_in = sweep_resp_ff;
      grows_in = grows_ff;
      gcols_in = gcols_ff;
      dgain_in = dgain_ff;
      sgain_in = sgain_ff;
      erate_in = erate_ff;
      placed_in = placed_ff;
      row_in = row_ff;
      col_in = col_ff;
      in_range_in = in_range_ff;
      wall_in = wall_ff;
      idx_in = idx_ff;
      rnd_in = rnd_ff;
      pr_in = pr_ff;
      pc_in = pc_ff;
      dr_in = dr_ff;
      dc_in = dc_ff;
      n_in = n_ff;
      sum_in = sum_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      j_in = j_ff;
      pick_in = pick_ff;
      er_in = er_ff;
      ec_in = ec_ff;
      res_status_in = res_status_ff;
      res_row_in = res_row_ff;
      res_col_in = res_col_ff;
      res_level_in = res_level_ff;
      res_mark_in = res_mark_ff;
      res_wall_in = res_wall_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_load = 1'b0;
      ph_we = 1'b0;
      ph_waddr = '0;
      ph_wdata = '0;
      ph_raddr = '0;
      mk_we = 1'b0;
      mk_waddr = '0;
      mk_wdata = '0;
      mk_raddr = '0;
      pos_we = 1'b0;
      pos_widx = idx_ff;
      pos_wrow = '0;
      pos_wcol = '0;
      slot_we = 1'b0;
      slot_w = '0;

      // Configuration writes, with the grid size clamped to its legal range.
      if (csr_write) begin
         case (csr_index)
            pgw_pkg::CSR_GRID_ROWS: begin
               if (clamp_v < 7'd3) grows_in = 7'd3;
               else if (32'(clamp_v) > MAX_ROWS) grows_in = DW'(MAX_ROWS);
               else grows_in = clamp_v;
            end
            pgw_pkg::CSR_GRID_COLUMNS: begin
               if (clamp_v < 7'd3) gcols_in = 7'd3;
               else if (32'(clamp_v) > MAX_COLUMNS) gcols_in = DW'(MAX_COLUMNS);
               else gcols_in = clamp_v;
            end
            pgw_pkg::CSR_DEPOSIT_GAIN: dgain_in = csr_data;
            pgw_pkg::CSR_SELF_GAIN:    sgain_in = csr_data;
            pgw_pkg::CSR_EVAP_RATE:    erate_in = csr_data;
            default: ;
         endcase
      end

      // The output register empties when its result is taken.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // A finished result moves to the output register once it has room.
      if (resp_pend_ff && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_load     = 1'b1;
         rsp_valid_in = 1'b1;
         resp_pend_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               row_in = RW'(req_cell_row);
               col_in = CW'(req_cell_col);
               in_range_in = (32'(req_cell_row) < MAX_ROWS) &&
                             (32'(req_cell_col) < MAX_COLUMNS);
               wall_in = !pgw_pkg::interior_plus1(req_r1, req_c1, grows_ff, gcols_ff);
               idx_in = req_idx;
               rnd_in = req_random_fraction;
               res_status_in = pgw_pkg::STATUS_DONE;
               res_row_in = '0;
               res_col_in = '0;
               res_level_in = '0;
               res_mark_in = pgw_pkg::MARK_FREE;
               res_wall_in = 1'b0;
               case (req_type)
                  pgw_pkg::REQ_CLEAR: begin
                     sweep_addr_in = '0;
                     sweep_resp_in = 1'b1;
                     state_in = S_SWEEP;
                  end
                  pgw_pkg::REQ_PLACE: begin
                     if (32'(placed_ff) >= MAX_ROBOTS) begin
                        res_status_in = pgw_pkg::STATUS_BAD;
                        resp_pend_in = 1'b1;
                     end else if (!pgw_pkg::interior_plus1(req_r1, req_c1, grows_ff,
                                                           gcols_ff)) begin
                        res_status_in = pgw_pkg::STATUS_REFUSED;
                        resp_pend_in = 1'b1;
                     end else begin
                        mk_raddr = {RW'(req_cell_row), CW'(req_cell_col)};
                        state_in = S_PLACE_CHK;
                     end
                  end
                  pgw_pkg::REQ_MOVE: begin
                     if (32'(req_robot_index) >= 32'(placed_ff)) begin
                        res_status_in = pgw_pkg::STATUS_BAD;
                        resp_pend_in = 1'b1;
                     end else begin
                        pr_in = pos_row_ff[req_idx];
                        pc_in = pos_col_ff[req_idx];
                        dr_in = '0;
                        dc_in = '0;
                        n_in = '0;
                        sum_in = '0;
                        state_in = S_NB_ADDR;
                     end
                  end
                  pgw_pkg::REQ_EVAP: begin
                     er_in = RW'(1);
                     ec_in = CW'(1);
                     state_in = S_EVAP_ADDR;
                  end
                  pgw_pkg::REQ_READ: begin
                     ph_raddr = {RW'(req_cell_row), CW'(req_cell_col)};
                     mk_raddr = {RW'(req_cell_row), CW'(req_cell_col)};
                     state_in = S_READ_WAIT;
                  end
                  default: begin
                     resp_pend_in = 1'b1;
                  end
               endcase
            end
         end

         // Zero both memories, one entry a cycle.
         S_SWEEP: begin
            ph_we = 1'b1;
            ph_waddr = sweep_addr_ff;
            mk_we = 1'b1;
            mk_waddr = sweep_addr_ff;
            if (sweep_addr_ff == AW'(DEPTH - 1)) begin
               placed_in = '0;
               resp_pend_in = sweep_resp_ff;
               state_in = S_IDLE;
            end else begin
               sweep_addr_in = sweep_addr_ff + AW'(1);
            end
         end

         // Place: the cell must hold no mark.
         S_PLACE_CHK: begin
            if (mk_rdata != pgw_pkg::MARK_FREE) begin
               res_status_in = pgw_pkg::STATUS_REFUSED;
            end else begin
               mk_we = 1'b1;
               mk_waddr = {row_ff, col_ff};
               mk_wdata = pgw_pkg::MARK_ROBOT;
               pos_we = 1'b1;
               pos_widx = placed_ff[IW-1:0];
               pos_wrow = row_ff;
               pos_wcol = col_ff;
               placed_in = placed_ff + PW'(1);
               res_row_in = 6'(row_ff);
               res_col_in = 6'(col_ff);
            end
            resp_pend_in = 1'b1;
            state_in = S_IDLE;
         end

         S_READ_WAIT: begin
            res_level_in = in_range_ff ? ph_rdata : '0;
            res_mark_in = in_range_ff ? mk_rdata : pgw_pkg::MARK_FREE;
            res_wall_in = wall_ff;
            resp_pend_in = 1'b1;
            state_in = S_IDLE;
         end

         // Scan the neighbourhood by row, then column; read each interior neighbour.
         S_NB_ADDR: begin
            if (dr_ff == 2'd3) begin
               if (own_ok) begin
                  ph_raddr = {pr_ff, pc_ff};
                  state_in = S_OWN_DATA;
               end else begin
                  state_in = S_ROUL_PREP;
               end
            end else if (slot_ok) begin
               ph_raddr = {slot_row, slot_col};
               state_in = S_NB_DATA;
            end else if (dc_ff == 2'd2) begin
               dc_in = '0;
               dr_in = dr_ff + 2'd1;
            end else begin
               dc_in = dc_ff + 2'd1;
            end
         end

         // Deposit on the neighbour and record its roulette weight.
         S_NB_DATA: begin
            ph_we = 1'b1;
            ph_waddr = {slot_row, slot_col};
            ph_wdata = dep_level;
            slot_we = 1'b1;
            slot_w = pgw_pkg::ONE_Q16 - dep_level;
            sum_in = sum_ff + 20'(pgw_pkg::ONE_Q16 - dep_level);
            n_in = n_ff + 4'd1;
            if (dc_ff == 2'd2) begin
               dc_in = '0;
               dr_in = dr_ff + 2'd1;
            end else begin
               dc_in = dc_ff + 2'd1;
            end
            state_in = S_NB_ADDR;
         end

         S_OWN_DATA: begin
            ph_we = 1'b1;
            ph_waddr = {pr_ff, pc_ff};
            ph_wdata = dep_level;
            state_in = S_ROUL_PREP;
         end

         // Scale the random fraction by the weight total for the roulette.
         S_ROUL_PREP: begin
            if (n_ff == 4'd0) begin
               res_status_in = pgw_pkg::STATUS_REFUSED;
               res_row_in = 6'(pr_ff);
               res_col_in = 6'(pc_ff);
               resp_pend_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               prod_in = 36'(rnd_ff) * 36'(sum_ff);
               pick_in = 3'(n_ff - 4'd1);
               j_in = '0;
               acc_in = '0;
               state_in = (sum_ff == '0) ? S_MARK_OLD : S_ROUL;
            end
         end

         // One neighbour per cycle: the first whose running weight reaches r.
         S_ROUL: begin
            acc_in = acc_next;
            if (acc_scaled >= prod_ff) begin
               pick_in = j_ff;
               state_in = S_MARK_OLD;
            end else if (4'(j_ff) == n_ff - 4'd1) begin
               state_in = S_MARK_OLD;
            end else begin
               j_in = j_ff + 3'd1;
            end
         end

         S_MARK_OLD: begin
            mk_we = 1'b1;
            mk_waddr = {pr_ff, pc_ff};
            mk_wdata = pgw_pkg::MARK_VISITED;
            state_in = S_MARK_NEW;
         end

         S_MARK_NEW: begin
            mk_we = 1'b1;
            mk_waddr = {nr_ff[pick_ff], nc_ff[pick_ff]};
            mk_wdata = pgw_pkg::MARK_ROBOT;
            pos_we = 1'b1;
            pos_widx = idx_ff;
            pos_wrow = nr_ff[pick_ff];
            pos_wcol = nc_ff[pick_ff];
            res_row_in = 6'(nr_ff[pick_ff]);
            res_col_in = 6'(nc_ff[pick_ff]);
            resp_pend_in = 1'b1;
            state_in = S_IDLE;
         end

         // Evaporate the interior, one cell per read and write-back.
         S_EVAP_ADDR: begin
            ph_raddr = {er_ff, ec_ff};
            state_in = S_EVAP_DATA;
         end

         S_EVAP_DATA: begin
            ph_we = 1'b1;
            ph_waddr = {er_ff, ec_ff};
            ph_wdata = pgw_pkg::evaporate_level(ph_rdata, erate_ff);
            state_in = S_EVAP_ADDR;
            if (9'(ec_ff) + 9'd2 >= 9'(gcols_ff)) begin
               ec_in = CW'(1);
               if (9'(er_ff) + 9'd2 >= 9'(grows_ff)) begin
                  resp_pend_in = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  er_in = er_ff + RW'(1);
               end
            end else begin
               ec_in = ec_ff + CW'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         resp_pend_ff  <= 1'b0;
         sweep_addr_ff <= '0;
         sweep_resp_ff <= 1'b0;
         grows_ff      <= DW'(ROWS_RESET);
         gcols_ff      <= DW'(COLS_RESET);
         dgain_ff      <= pgw_pkg::DEPOSIT_GAIN_RESET;
         sgain_ff      <= pgw_pkg::SELF_GAIN_RESET;
         erate_ff      <= pgw_pkg::EVAP_RATE_RESET;
         placed_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         resp_pend_ff  <= resp_pend_in;
         sweep_addr_ff <= sweep_addr_in;
         sweep_resp_ff <= sweep_resp_in;
         grows_ff      <= grows_in;
         gcols_ff      <= gcols_in;
         dgain_ff      <= dgain_in;
         sgain_ff      <= sgain_in;
         erate_ff      <= erate_in;
         placed_ff     <= placed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      row_ff <= row_in;
      col_ff <= col_in;
      in_range_ff <= in_range_in;
      wall_ff <= wall_in;
      idx_ff <= idx_in;
      rnd_ff <= rnd_in;
      pr_ff <= pr_in;
      pc_ff <= pc_in;
      dr_ff <= dr_in;
      dc_ff <= dc_in;
      n_ff <= n_in;
      sum_ff <= sum_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      j_ff <= j_in;
      pick_ff <= pick_in;
      er_ff <= er_in;
      ec_ff <= ec_in;
      res_status_ff <= res_status_in;
      res_row_ff <= res_row_in;
      res_col_ff <= res_col_in;
      res_level_ff <= res_level_in;
      res_mark_ff <= res_mark_in;
      res_wall_ff <= res_wall_in;
      if (slot_we) begin
         w_ff[n_ff[2:0]]  <= slot_w;
         nr_ff[n_ff[2:0]] <= slot_row;
         nc_ff[n_ff[2:0]] <= slot_col;
      end
      if (pos_we) begin
         pos_row_ff[pos_widx] <= pos_wrow;
         pos_col_ff[pos_widx] <= pos_wcol;
      end
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_row_ff    <= res_row_ff;
         rsp_col_ff    <= res_col_ff;
         rsp_level_ff  <= res_level_ff;
         rsp_mark_ff   <= res_mark_ff;
         rsp_wall_ff   <= res_wall_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_robot_row = rsp_row_ff;
   assign rsp_robot_col = rsp_col_ff;
   assign rsp_level     = rsp_level_ff;
   assign rsp_cell_mark = rsp_mark_ff;
   assign rsp_is_wall   = rsp_wall_ff;

   // The roulette never steps past the neighbours that were recorded.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUL) |-> (4'(j_ff) < n_ff))
      else $error("roulette index beyond neighbour count");

   // At most eight neighbours are ever collected.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUL_PREP) |-> (n_ff <= 4'd8))
      else $error("neighbour count above eight");

   // The robot count stays within the robot table.
   assert property (@(posedge clock) disable iff (reset)
      32'(placed_ff) <= MAX_ROBOTS)
      else $error("robot count above table size");

   // A taken request always leaves the idle state or queues a result.
   assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff != S_IDLE) || resp_pend_ff)
      else $error("request taken without any work started");

   // A bad request reports no position.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_load && res_status_ff == pgw_pkg::STATUS_BAD) |=>
         (rsp_row_ff == 6'd0) && (rsp_col_ff == 6'd0))
      else $error("position reported with bad status");

endmodule

`default_nettype wire
